// ===== rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Round constants, initial chaining words, working-variable type and helpers
// shared by the hash engine and its round unit.
// ----------------------------------------------------------------------------
package sha1_pkg;

	localparam int ROUNDS       = 80;
	localparam int ROUND_W      = $clog2(ROUNDS);
	localparam int DIGEST_WORDS = 5;
	localparam int IDX_W        = $clog2(DIGEST_WORDS);

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	// entry 0 is H0
	localparam logic [DIGEST_WORDS-1:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} sha1_vars_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== rtl/sha1_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 channel interfaces
// Valid/ready channels for message beats and digest beats.
// ----------------------------------------------------------------------------
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source(output valid, mode, data_byte, input ready);
	modport sink(input valid, mode, data_byte, output ready);
endinterface

interface sha1_out_if;
	logic                           valid;
	logic                           ready;
	logic [31:0]                    digest_word;
	logic [sha1_pkg::IDX_W-1:0]     word_index;
	logic                           last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/sha1_hash_engine.sv =====
// Sequence: a data beat is taken in S_IDLE; the 64th byte of a block runs the
// rounds in S_ROUND, then the chaining add in S_ADD. A finish beat pads to the
// block end at one byte per cycle and compresses; if the length does not fit,
// a second pad block and compression follow, then 5 digest beats. No beat is
// taken outside S_IDLE; the rounds run at one round per cycle.
// Reset loads the initial chaining words and clears the bit count.
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Byte-fed SHA-1 with a 512-bit shift buffer that doubles as the rolling
// message schedule, one shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
	input  logic               clk,
	input  logic               arst_n,
	sha1_in_if.sink            msg,
	sha1_out_if.source         dig
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROUND = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_PAD   = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	localparam logic [sha1_pkg::ROUND_W-1:0] RND_LAST =
		sha1_pkg::ROUND_W'(sha1_pkg::ROUNDS - 1);
	localparam logic [sha1_pkg::IDX_W-1:0] IDX_LAST =
		sha1_pkg::IDX_W'(sha1_pkg::DIGEST_WORDS - 1);

	logic [2:0]                                 state_q;
	logic [sha1_pkg::ROUND_W-1:0]               rnd_q;
	logic [5:0]                                 pos_q;
	logic [63:0]                                msg_bits_q;
	logic [sha1_pkg::DIGEST_WORDS-1:0][31:0]    chain_q;
	logic [sha1_pkg::IDX_W-1:0]                 idx_q;
	logic                                       fin_q;
	logic                                       first_q;
	logic                                       final_q;
	sha1_pkg::sha1_vars_t                       vars_q;
	logic [511:0]                               buf_q;

	sha1_pkg::sha1_vars_t  vars_nxt;
	sha1_pkg::sha1_vars_t  chain_vars;
	logic [31:0]           w_new;
	logic [7:0]            len_byte;
	logic [7:0]            pad_byte;
	logic [7:0]            push_byte;
	logic                  push;
	logic                  data_beat;
	logic                  fin_beat;

	assign msg.ready = (state_q == S_IDLE);
	assign data_beat = msg.valid && msg.ready && !msg.mode;
	assign fin_beat  = msg.valid && msg.ready && msg.mode;

	// length bytes go out most significant first at positions 56..63
	assign len_byte = msg_bits_q[{3'd7 - pos_q[2:0], 3'b000} +: 8];

	always_comb begin
		if (first_q) begin
			pad_byte = sha1_pkg::PAD_MARK;
		end else if (final_q && pos_q >= sha1_pkg::LEN_POS) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign push      = data_beat || (state_q == S_PAD);
	assign push_byte = (state_q == S_PAD) ? pad_byte : msg.data_byte;

	// schedule taps: W[t], W[t+2], W[t+8], W[t+13] from the top of the buffer
	assign w_new = sha1_pkg::rotl(buf_q[511 -: 32] ^ buf_q[447 -: 32]
		^ buf_q[255 -: 32] ^ buf_q[95 -: 32], 1);

	assign chain_vars = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
		d: chain_q[3], e: chain_q[4]};

	sha1_round u_round (
		.cur (vars_q),
		.w   (buf_q[511 -: 32]),
		.rnd (rnd_q),
		.nxt (vars_nxt)
	);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q <= {buf_q[503:0], push_byte};
		end else if (state_q == S_ROUND) begin
			buf_q <= {buf_q[479:0], w_new};
		end
		if (state_q == S_ROUND) begin
			vars_q <= vars_nxt;
		end else begin
			vars_q <= chain_vars;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rnd_q      <= '0;
			pos_q      <= '0;
			msg_bits_q <= '0;
			chain_q    <= sha1_pkg::H_INIT;
			idx_q      <= '0;
			fin_q      <= 1'b0;
			first_q    <= 1'b0;
			final_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (data_beat) begin
						pos_q      <= pos_q + 6'd1;
						msg_bits_q <= msg_bits_q + 64'd8;
						fin_q      <= 1'b0;
						if (pos_q == sha1_pkg::LAST_POS) begin
							rnd_q   <= '0;
							state_q <= S_ROUND;
						end
					end else if (fin_beat) begin
						fin_q   <= 1'b1;
						first_q <= 1'b1;
						final_q <= 1'b0;
						state_q <= S_PAD;
					end
				end
				S_PAD: begin
					pos_q   <= pos_q + 6'd1;
					first_q <= 1'b0;
					// length fits after the marker only below offset 56
					if (first_q) begin
						final_q <= (pos_q < sha1_pkg::LEN_POS);
					end
					if (pos_q == sha1_pkg::LAST_POS) begin
						rnd_q   <= '0;
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + sha1_pkg::ROUND_W'(1);
					if (rnd_q == RND_LAST) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + vars_q.a;
					chain_q[1] <= chain_q[1] + vars_q.b;
					chain_q[2] <= chain_q[2] + vars_q.c;
					chain_q[3] <= chain_q[3] + vars_q.d;
					chain_q[4] <= chain_q[4] + vars_q.e;
					if (!fin_q) begin
						state_q <= S_IDLE;
					end else if (final_q) begin
						idx_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						// marker block done, length goes in the next one
						final_q <= 1'b1;
						state_q <= S_PAD;
					end
				end
				S_EMIT: begin
					if (dig.ready) begin
						if (idx_q == IDX_LAST) begin
							chain_q    <= sha1_pkg::H_INIT;
							msg_bits_q <= '0;
							fin_q      <= 1'b0;
							final_q    <= 1'b0;
							state_q    <= S_IDLE;
						end else begin
							idx_q <= idx_q + sha1_pkg::IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign dig.valid       = (state_q == S_EMIT);
	assign dig.digest_word = chain_q[idx_q];
	assign dig.word_index  = idx_q;
	assign dig.last_word   = (idx_q == IDX_LAST);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && dig.valid))
		else $error("input ready while digest beat pending");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (idx_q <= IDX_LAST))
		else $error("digest word index out of range");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == RND_LAST) |=> (state_q == S_ADD))
		else $error("compression did not finish after last round");

	a_emit_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (pos_q == 6'd0 && fin_q))
		else $error("digest emitted with partial block");
`endif

endmodule

// ===== rtl/sha1_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: selects the boolean function and constant for the
// round number and forms the next working variables.
// ----------------------------------------------------------------------------
module sha1_round (
	input  sha1_pkg::sha1_vars_t            cur,
	input  logic [31:0]                     w,
	input  logic [sha1_pkg::ROUND_W-1:0]    rnd,
	output sha1_pkg::sha1_vars_t            nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < sha1_pkg::ROUND_W'(20)) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1_pkg::K0;
		end else if (rnd < sha1_pkg::ROUND_W'(40)) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K1;
		end else if (rnd < sha1_pkg::ROUND_W'(60)) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1_pkg::K2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1_pkg::K3;
		end
	end

	always_comb begin
		nxt.a = sha1_pkg::rotl(cur.a, 5) + f + cur.e + w + k;
		nxt.b = cur.a;
		nxt.c = sha1_pkg::rotl(cur.b, 30);
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

// ===== verif/tb_sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Feeds byte messages and finish beats through the message channel. A local
// SHA-1 model predicts each digest, and the five digest beats are checked
// word by word as they leave. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_sha1_hash_engine;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_BEATS = 280;
	localparam int RANDOM_MESSAGES = 8;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hEFCDAB89;
	localparam logic [31:0] IV_C = 32'h98BADCFE;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] IV_E = 32'hC3D2E1F0;

	localparam logic [31:0] RC_CHOOSE = 32'h5A827999;
	localparam logic [31:0] RC_PARITY1 = 32'h6ED9EBA1;
	localparam logic [31:0] RC_MAJORITY = 32'h8F1BBCDC;
	localparam logic [31:0] RC_PARITY2 = 32'hCA62C1D6;

	typedef struct {
		logic [31:0]                word;
		logic [sha1_pkg::IDX_W-1:0] index;
		logic                       last;
	} digest_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sha1_in_if  msg_if();
	sha1_out_if dig_if();

	sha1_hash_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.dig    (dig_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hash state mirrored from the stream of accepted beats
	logic [31:0] chain_words [5];
	logic [7:0]  block_buf [64];
	logic [63:0] bit_count;

	digest_beat_t expected_digest_words [$];

	int errors = 0;
	int cycles = 0;
	int beats_sent = 0;
	int messages_done = 0;
	int stall_left = 0;
	bit steady = 1'b0;

	// ---------------------------------------------------------------- model

	function automatic void load_iv();
		chain_words[0] = IV_A;
		chain_words[1] = IV_B;
		chain_words[2] = IV_C;
		chain_words[3] = IV_D;
		chain_words[4] = IV_E;
		bit_count = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int i;
		for (i = 0; i < 16; i++) begin
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		end
		a = chain_words[0];
		b = chain_words[1];
		c = chain_words[2];
		d = chain_words[3];
		e = chain_words[4];
		for (i = 0; i < 80; i++) begin
			if (i >= 16) begin
				x = w[(i+13) & 15] ^ w[(i+8) & 15] ^ w[(i+2) & 15] ^ w[i & 15];
				w[i & 15] = {x[30:0], x[31]};
			end
			case (i / 20)
				0: begin
					f = (b & c) | (~b & d);
					k = RC_CHOOSE;
				end
				1: begin
					f = b ^ c ^ d;
					k = RC_PARITY1;
				end
				2: begin
					f = (b & c) | (b & d) | (c & d);
					k = RC_MAJORITY;
				end
				default: begin
					f = b ^ c ^ d;
					k = RC_PARITY2;
				end
			endcase
			t = {a[26:0], a[31:27]} + f + e + w[i & 15] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_words[0] += a;
		chain_words[1] += b;
		chain_words[2] += c;
		chain_words[3] += d;
		chain_words[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] value);
		int pos;
		pos = int'(bit_count[8:3]);
		block_buf[pos] = value;
		bit_count += 64'd8;
		if (pos == 63)
			compress_block();
	endfunction

	// pad, append the length, compress and queue the five digest words
	function automatic void finish_message();
		int pos;
		int k;
		digest_beat_t beat;
		pos = int'(bit_count[8:3]);
		block_buf[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				block_buf[pos] = 8'h00;
				pos++;
			end
			compress_block();
			pos = 0;
		end
		while (pos < 56) begin
			block_buf[pos] = 8'h00;
			pos++;
		end
		for (k = 0; k < 8; k++)
			block_buf[56 + k] = bit_count[63 - 8*k -: 8];
		compress_block();
		for (k = 0; k < 5; k++) begin
			beat.word = chain_words[k];
			beat.index = k[sha1_pkg::IDX_W-1:0];
			beat.last = (k == 4);
			expected_digest_words.push_back(beat);
		end
		load_iv();
	endfunction

	// ---------------------------------------------------------------- driving

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// entered just after a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input logic mode, input logic [7:0] value);
		int gap;
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			msg_if.valid <= 1'b0;
			msg_if.data_byte <= 8'($urandom);
			repeat (gap) @(negedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.mode <= mode;
		msg_if.data_byte <= value;
		do
			@(posedge clk);
		while (!msg_if.ready);
		beats_sent++;
		if (mode == MODE_APPEND) begin
			absorb_byte(value);
		end else begin
			finish_message();
			messages_done++;
		end
	endtask

	task automatic send_message(input int len, input logic [7:0] finish_byte);
		int i;
		for (i = 0; i < len; i++)
			send_beat(MODE_APPEND, 8'($urandom));
		send_beat(MODE_FINISH, finish_byte);
	endtask

	// digest side: stall the sink in bursts unless a steady stretch is on
	always @(negedge clk) begin
		if (stall_left > 0) begin
			dig_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			dig_if.ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && dig_if.valid && dig_if.ready) begin
			if (expected_digest_words.size() == 0) begin
				report_mismatch($sformatf("digest beat %h with nothing expected",
					dig_if.digest_word));
			end else begin
				want = expected_digest_words.pop_front();
				if (dig_if.digest_word !== want.word)
					report_mismatch($sformatf("digest_word %h, want %h",
						dig_if.digest_word, want.word));
				if (dig_if.word_index !== want.index)
					report_mismatch($sformatf("word_index %0d, want %0d",
						dig_if.word_index, want.index));
				if (dig_if.last_word !== want.last)
					report_mismatch($sformatf("last_word %b, want %b",
						dig_if.last_word, want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[sha1_hash_engine] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	task automatic test_empty_message();
		send_beat(MODE_FINISH, 8'h00);
		steady = 1'b1;
		send_beat(MODE_FINISH, 8'h00);
		steady = 1'b0;
	endtask

	task automatic test_abc_message();
		send_beat(MODE_APPEND, 8'h61);
		send_beat(MODE_APPEND, 8'h62);
		send_beat(MODE_APPEND, 8'h63);
		send_beat(MODE_FINISH, 8'h00);
	endtask

	task automatic test_byte_extremes();
		send_beat(MODE_APPEND, 8'h00);
		send_beat(MODE_APPEND, 8'hFF);
		send_beat(MODE_APPEND, 8'h00);
		send_beat(MODE_APPEND, 8'hFF);
		send_beat(MODE_APPEND, 8'h55);
		send_beat(MODE_APPEND, 8'hAA);
		send_beat(MODE_FINISH, 8'h00);
	endtask

	// the byte on a finish beat must not reach the digest
	task automatic test_finish_ignores_byte();
		send_beat(MODE_APPEND, 8'h12);
		send_beat(MODE_APPEND, 8'h34);
		send_beat(MODE_FINISH, 8'hFF);
		send_beat(MODE_FINISH, 8'hA5);
	endtask

	// mostly short messages, some on the padding boundaries, a few multi-block
	task automatic test_random_messages();
		int r;
		int len;
		int boundary [6] = '{55, 56, 57, 63, 64, 65};
		while (beats_sent < RANDOM_BEATS || messages_done < RANDOM_MESSAGES) begin
			steady = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 55)
				len = $urandom_range(0, 20);
			else if (r < 75)
				len = boundary[$urandom_range(0, 5)];
			else if (r < 90)
				len = $urandom_range(21, 70);
			else
				len = $urandom_range(100, 130);
			send_message(len, 8'($urandom));
		end
		steady = 1'b0;
	endtask

	initial begin
		msg_if.valid = 1'b0;
		msg_if.mode = MODE_APPEND;
		msg_if.data_byte = 8'h00;
		dig_if.ready = 1'b0;
		load_iv();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_empty_message();
		test_abc_message();
		test_byte_extremes();
		test_finish_ignores_byte();
		test_random_messages();

		@(negedge clk);
		msg_if.valid <= 1'b0;
		while (expected_digest_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[sha1_hash_engine] OK");
		else
			$display("[sha1_hash_engine] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_round.sv
rtl/sha1_hash_engine.sv
verif/tb_sha1_hash_engine.sv
